// ----- rtl/wrdpj_pkg.sv -----
package wrdpj_pkg;

  // Widths fixed by the pixel and result formats
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned DIM_W   = 10;
  localparam int unsigned WGT_W   = 4;
  localparam int unsigned THR_W   = 25;
  localparam int unsigned SUM_W   = 22;
  localparam int unsigned VERD_W  = 3;
  localparam int unsigned CFG_A_W = 3;

  // Shared multiplier: threshold (25 b) by frame weight (24 b)
  localparam int unsigned MUL_A_W = 25;
  localparam int unsigned MUL_B_W = 24;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Q1.24 scale of the thresholds
  localparam int unsigned FRAC_W = 24;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Verdict codes
  localparam logic [VERD_W-1:0] VERDICT_NONE  = 3'd0;
  localparam logic [VERD_W-1:0] VERDICT_LEFT  = 3'd1;
  localparam logic [VERD_W-1:0] VERDICT_RIGHT = 3'd2;
  localparam logic [VERD_W-1:0] VERDICT_BLACK = 3'd3;
  localparam logic [VERD_W-1:0] VERDICT_WHITE = 3'd4;

  // Register indexes
  localparam logic [CFG_A_W-1:0] CFG_FRAME_ROWS   = 3'd0;
  localparam logic [CFG_A_W-1:0] CFG_FRAME_COLS   = 3'd1;
  localparam logic [CFG_A_W-1:0] CFG_UPPER_WEIGHT = 3'd2;
  localparam logic [CFG_A_W-1:0] CFG_LOWER_WEIGHT = 3'd3;
  localparam logic [CFG_A_W-1:0] CFG_BLACK_THR    = 3'd4;
  localparam logic [CFG_A_W-1:0] CFG_WHITE_THR    = 3'd5;
  localparam logic [CFG_A_W-1:0] CFG_TURN_THR     = 3'd6;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } pix_t;

  typedef struct packed {
    logic [VERD_W-1:0] verdict;
    logic [SUM_W-1:0]  weighted_dark;
    logic [SUM_W-1:0]  left_sum;
    logic [SUM_W-1:0]  middle_sum;
    logic [SUM_W-1:0]  right_sum;
  } res_t;

  // Live configuration, frame size already clamped
  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic [WGT_W-1:0] upper_w;
    logic [WGT_W-1:0] lower_w;
    logic [THR_W-1:0] black_thr;
    logic [THR_W-1:0] white_thr;
    logic [THR_W-1:0] turn_thr;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] dark;
    logic [SUM_W-1:0] left;
    logic [SUM_W-1:0] middle;
    logic [SUM_W-1:0] right;
  } sums_t;

  // Saturating accumulate of one weight
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                               input logic [WGT_W-1:0] w);
    logic [SUM_W:0] t;
    t = {1'b0, s} + (SUM_W+1)'(w);
    return t[SUM_W] ? SUM_MAX : t[SUM_W-1:0];
  endfunction

endpackage

// ----- rtl/wrdpj_mul.sv -----
module wrdpj_mul (
  input  logic                              clk_i,
  input  logic [wrdpj_pkg::MUL_A_W-1:0]     a_i,
  input  logic [wrdpj_pkg::MUL_B_W-1:0]     b_i,
  output logic [wrdpj_pkg::MUL_P_W-1:0]     p_o
);

  // Shared multiplier, product registered
  logic [wrdpj_pkg::MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= wrdpj_pkg::MUL_P_W'(a_i) * wrdpj_pkg::MUL_P_W'(b_i);
  end

  assign p_o = p_q;

endmodule

// ----- rtl/wrdpj_acc.sv -----
module wrdpj_acc #(
  parameter int unsigned MAX_ROWS = 512,
  parameter int unsigned MAX_COLS = 512
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wrdpj_pkg::cfg_t      cfg_i,
  input  logic                 take_i,
  input  wrdpj_pkg::pix_t      pix_i,
  input  logic                 clear_i,
  output logic                 frame_end_o,
  output wrdpj_pkg::sums_t     sums_o
);

  localparam int unsigned RW = $clog2(MAX_ROWS);
  localparam int unsigned CW = $clog2(MAX_COLS);
  localparam int unsigned RX = ((RW > wrdpj_pkg::DIM_W) ? RW : wrdpj_pkg::DIM_W) + 1;
  localparam int unsigned CX = ((CW > 12) ? CW : 12) + 1;

  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  wrdpj_pkg::sums_t sums_q, sums_d;

  logic [RX-1:0] row_x, rows_x;
  logic [CX-1:0] col_x, cols_x, half_x, qtr_x, q3_x;
  logic          row_last, col_last, upper, dark;
  logic [wrdpj_pkg::WGT_W-1:0] wt;

  // Position compares, widened so a mid-frame size change still ends rows
  assign row_x    = RX'(row_q);
  assign rows_x   = RX'(cfg_i.rows);
  assign col_x    = CX'(col_q);
  assign cols_x   = CX'(cfg_i.cols);
  assign row_last = (row_x + RX'(1)) >= rows_x;
  assign col_last = (col_x + CX'(1)) >= cols_x;
  assign upper    = row_x < (rows_x >> 1);
  assign half_x   = cols_x >> 1;
  assign qtr_x    = cols_x >> 2;
  assign q3_x     = (cols_x * CX'(3)) >> 2;

  assign dark = (pix_i.blue == '0) && (pix_i.green == '0) && (pix_i.red == '0);
  assign wt   = upper ? cfg_i.upper_w : cfg_i.lower_w;

  assign frame_end_o = take_i && col_last && row_last;

  // Raster position
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (take_i) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  // Region sums
  always_comb begin
    sums_d = sums_q;
    if (clear_i) begin
      sums_d = '0;
    end else if (take_i && dark) begin
      sums_d.dark = wrdpj_pkg::sat_add(sums_q.dark, wt);
      if (col_x < half_x) begin
        sums_d.left = wrdpj_pkg::sat_add(sums_q.left, wt);
      end else begin
        sums_d.right = wrdpj_pkg::sat_add(sums_q.right, wt);
      end
      if (col_x >= qtr_x && col_x < q3_x) begin
        sums_d.middle = wrdpj_pkg::sat_add(sums_q.middle, wt);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      sums_q <= '0;
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      sums_q <= sums_d;
    end
  end

  assign sums_o = sums_q;

endmodule

// ----- rtl/wrdpj_judge.sv -----
module wrdpj_judge (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  wrdpj_pkg::cfg_t                   cfg_i,
  input  wrdpj_pkg::sums_t                  sums_i,
  input  logic                              frame_end_i,
  output logic                              busy_o,
  output logic                              clear_o,
  output logic [wrdpj_pkg::MUL_A_W-1:0]     mul_a_o,
  output logic [wrdpj_pkg::MUL_B_W-1:0]     mul_b_o,
  input  logic [wrdpj_pkg::MUL_P_W-1:0]     mul_p_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output wrdpj_pkg::res_t                   out_word_o
);

  localparam logic [2:0] ST_PIX  = 3'd0;
  localparam logic [2:0] ST_SIZE = 3'd1;
  localparam logic [2:0] ST_WGT  = 3'd2;
  localparam logic [2:0] ST_BLK  = 3'd3;
  localparam logic [2:0] ST_WHT  = 3'd4;
  localparam logic [2:0] ST_TRN  = 3'd5;
  localparam logic [2:0] ST_DEC  = 3'd6;

  localparam int unsigned PW = wrdpj_pkg::MUL_P_W;
  localparam int unsigned BW = wrdpj_pkg::MUL_B_W;
  localparam int unsigned SW = wrdpj_pkg::SUM_W;
  localparam int unsigned FW = wrdpj_pkg::FRAC_W;

  logic [2:0]    state_q, state_d;
  logic [BW-1:0] w_q;
  logic          blk_q, wht_q;
  logic          out_valid_q;
  wrdpj_pkg::res_t out_q;

  logic [4:0]    wsum;
  logic [BW-1:0] dark_x, wdiff;
  logic          w_gt, lr_ge, turn_hit, load;
  logic [SW-1:0] side, tdiff;
  logic [PW-1:0] cmp_lhs;
  logic          cmp_gt;
  logic [wrdpj_pkg::VERD_W-1:0] verdict;

  assign wsum = {1'b0, cfg_i.upper_w} + {1'b0, cfg_i.lower_w};

  // Operand select for the shared multiplier
  always_comb begin
    mul_a_o = '0;
    mul_b_o = '0;
    case (state_q)
      ST_SIZE: begin
        mul_a_o = wrdpj_pkg::MUL_A_W'(cfg_i.rows);
        mul_b_o = BW'(cfg_i.cols);
      end
      ST_WGT: begin
        mul_a_o = wrdpj_pkg::MUL_A_W'(mul_p_i[20:1]);
        mul_b_o = BW'(wsum);
      end
      ST_BLK: begin
        mul_a_o = cfg_i.black_thr;
        mul_b_o = mul_p_i[BW-1:0];
      end
      ST_WHT: begin
        mul_a_o = cfg_i.white_thr;
        mul_b_o = w_q;
      end
      ST_TRN, ST_DEC: begin
        mul_a_o = cfg_i.turn_thr;
        mul_b_o = w_q;
      end
      default: begin
        mul_a_o = '0;
        mul_b_o = '0;
      end
    endcase
  end

  // Left side of the shared compare: scaled dark, light or turn margin
  assign dark_x = BW'(sums_i.dark);
  assign w_gt   = w_q > dark_x;
  assign wdiff  = w_q - dark_x;
  assign lr_ge  = sums_i.left >= sums_i.right;
  assign side   = lr_ge ? sums_i.left : sums_i.right;
  assign tdiff  = (side >= sums_i.middle) ? side - sums_i.middle : sums_i.middle - side;

  always_comb begin
    case (state_q)
      ST_WHT:  cmp_lhs = {3'b000, sums_i.dark, {FW{1'b0}}};
      ST_TRN:  cmp_lhs = w_gt ? {1'b0, wdiff, {FW{1'b0}}} : '0;
      ST_DEC:  cmp_lhs = {3'b000, tdiff, {FW{1'b0}}};
      default: cmp_lhs = '0;
    endcase
  end

  assign cmp_gt   = cmp_lhs > mul_p_i;
  assign turn_hit = cmp_gt;

  // Verdict in priority order
  always_comb begin
    if (blk_q) begin
      verdict = wrdpj_pkg::VERDICT_BLACK;
    end else if (wht_q) begin
      verdict = wrdpj_pkg::VERDICT_WHITE;
    end else if (turn_hit) begin
      verdict = lr_ge ? wrdpj_pkg::VERDICT_LEFT : wrdpj_pkg::VERDICT_RIGHT;
    end else begin
      verdict = wrdpj_pkg::VERDICT_NONE;
    end
  end

  assign load = (state_q == ST_DEC) && (!out_valid_q || !out_stall_i);

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_PIX:  if (frame_end_i) state_d = ST_SIZE;
      ST_SIZE: state_d = ST_WGT;
      ST_WGT:  state_d = ST_BLK;
      ST_BLK:  state_d = ST_WHT;
      ST_WHT:  state_d = ST_TRN;
      ST_TRN:  state_d = ST_DEC;
      ST_DEC:  if (load) state_d = ST_PIX;
      default: state_d = ST_PIX;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_PIX;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Judge working registers and result word
  always_ff @(posedge clk_i) begin
    if (state_q == ST_BLK) begin
      w_q <= mul_p_i[BW-1:0];
    end
    if (state_q == ST_WHT) begin
      blk_q <= cmp_gt;
    end
    if (state_q == ST_TRN) begin
      wht_q <= cmp_gt;
    end
    if (load) begin
      out_q.verdict       <= verdict;
      out_q.weighted_dark <= sums_i.dark;
      out_q.left_sum      <= sums_i.left;
      out_q.middle_sum    <= sums_i.middle;
      out_q.right_sum     <= sums_i.right;
    end
  end

  assign busy_o      = state_q != ST_PIX;
  assign clear_o     = load;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ----- rtl/weighted_region_dark_pixel_judge.sv -----
// Dark-pixel judge: pixels stream in raster order, one word per clock while
// a frame is in progress; row and column are counted here against the
// frame_rows and frame_cols registers (clamped to 2..MAX_ROWS, 4..MAX_COLS).
// Only the last pixel of a frame yields a result word: after it the input is
// stalled while the sequencer drives a single shared 25x24 multiplier through
// frame size, total weight and the three threshold products, one per cycle,
// against one shared comparator. The result then sits in an output register
// and the next frame may start at once; should a second frame end before the
// previous word is taken, input stays stalled until it is. Sums saturate at
// 2^22-1 and are cleared as the word is loaded.
module weighted_region_dark_pixel_judge #(
  parameter int unsigned MAX_ROWS = 512,
  parameter int unsigned MAX_COLS = 512
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  wrdpj_pkg::pix_t                     in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output wrdpj_pkg::res_t                     out_word_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [wrdpj_pkg::CFG_A_W-1:0]       cfg_index_i,
  input  logic [wrdpj_pkg::THR_W-1:0]         cfg_data_i
);

  localparam logic [wrdpj_pkg::DIM_W-1:0] ROWS_HI =
    (MAX_ROWS > 1023) ? 10'd1023 : wrdpj_pkg::DIM_W'(MAX_ROWS);
  localparam logic [wrdpj_pkg::DIM_W-1:0] COLS_HI =
    (MAX_COLS > 1023) ? 10'd1023 : wrdpj_pkg::DIM_W'(MAX_COLS);

  logic [wrdpj_pkg::DIM_W-1:0] rows_q, cols_q;
  logic [wrdpj_pkg::WGT_W-1:0] upper_q, lower_q;
  logic [wrdpj_pkg::THR_W-1:0] black_q, white_q, turn_q;

  wrdpj_pkg::cfg_t  cfg;
  wrdpj_pkg::sums_t sums;
  logic             take, frame_end, busy, sum_clr;
  logic [wrdpj_pkg::MUL_A_W-1:0] mul_a;
  logic [wrdpj_pkg::MUL_B_W-1:0] mul_b;
  logic [wrdpj_pkg::MUL_P_W-1:0] mul_p;

  // Register file
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= 10'd128;
      cols_q  <= 10'd256;
      upper_q <= 4'd3;
      lower_q <= 4'd7;
      black_q <= 25'd15938355;
      white_q <= 25'd15938355;
      turn_q  <= 25'd8389;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        wrdpj_pkg::CFG_FRAME_ROWS:   rows_q  <= cfg_data_i[9:0];
        wrdpj_pkg::CFG_FRAME_COLS:   cols_q  <= cfg_data_i[9:0];
        wrdpj_pkg::CFG_UPPER_WEIGHT: upper_q <= cfg_data_i[3:0];
        wrdpj_pkg::CFG_LOWER_WEIGHT: lower_q <= cfg_data_i[3:0];
        wrdpj_pkg::CFG_BLACK_THR:    black_q <= cfg_data_i;
        wrdpj_pkg::CFG_WHITE_THR:    white_q <= cfg_data_i;
        wrdpj_pkg::CFG_TURN_THR:     turn_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the frame size
  always_comb begin
    cfg.rows      = (rows_q < 10'd2) ? 10'd2 : ((rows_q > ROWS_HI) ? ROWS_HI : rows_q);
    cfg.cols      = (cols_q < 10'd4) ? 10'd4 : ((cols_q > COLS_HI) ? COLS_HI : cols_q);
    cfg.upper_w   = upper_q;
    cfg.lower_w   = lower_q;
    cfg.black_thr = black_q;
    cfg.white_thr = white_q;
    cfg.turn_thr  = turn_q;
  end

  assign in_stall_o = busy;
  assign take       = in_valid_i && !in_stall_o;

  wrdpj_acc #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .take_i      (take),
    .pix_i       (in_word_i),
    .clear_i     (sum_clr),
    .frame_end_o (frame_end),
    .sums_o      (sums)
  );

  wrdpj_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  wrdpj_judge u_judge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .sums_i      (sums),
    .frame_end_i (frame_end),
    .busy_o      (busy),
    .clear_o     (sum_clr),
    .mul_a_o     (mul_a),
    .mul_b_o     (mul_b),
    .mul_p_i     (mul_p),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // A frame end always holds off the next pixel
  a_end_stalls : assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_end |=> in_stall_o)
    else $error("input not stalled after frame end");

  // Loading the result word empties the sums
  a_clr_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_clr |=> (sums.dark == '0 && sums.left == '0 && sums.middle == '0
                 && sums.right == '0))
    else $error("sums not cleared after result load");

  // No region can exceed the frame total
  a_region_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.left_sum <= out_word_o.weighted_dark
                     && out_word_o.middle_sum <= out_word_o.weighted_dark
                     && out_word_o.right_sum <= out_word_o.weighted_dark))
    else $error("region sum above frame total");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned MAX_ROWS      = 512;
  localparam int unsigned MAX_COLS      = 512;
  localparam int unsigned SETTLE_CYCLES = 16;   // margin for the sequencer to finish
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned RANDOM_PIXELS = 120;

  // Index with no register behind it
  localparam logic [wrdpj_pkg::CFG_A_W-1:0] CFG_SPARE = 3'd7;

  typedef enum int {SHAPE_FLAT, SHAPE_LEFT, SHAPE_RIGHT, SHAPE_MIDDLE} shape_e;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  wrdpj_pkg::pix_t               in_word_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  wrdpj_pkg::res_t               out_word_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [wrdpj_pkg::CFG_A_W-1:0] cfg_index_i;
  logic [wrdpj_pkg::THR_W-1:0]   cfg_data_i;

  // Predicted register contents, reset values
  logic [wrdpj_pkg::DIM_W-1:0] cfg_rows  = 10'd128;
  logic [wrdpj_pkg::DIM_W-1:0] cfg_cols  = 10'd256;
  logic [wrdpj_pkg::WGT_W-1:0] cfg_upper = 4'd3;
  logic [wrdpj_pkg::WGT_W-1:0] cfg_lower = 4'd7;
  logic [wrdpj_pkg::THR_W-1:0] thr_black = 25'd15938355;
  logic [wrdpj_pkg::THR_W-1:0] thr_white = 25'd15938355;
  logic [wrdpj_pkg::THR_W-1:0] thr_turn  = 25'd8389;

  // Predicted frame position and sums
  int unsigned                 row_at, col_at;
  logic [wrdpj_pkg::SUM_W-1:0] dark_acc  = '0;
  logic [wrdpj_pkg::SUM_W-1:0] left_acc  = '0;
  logic [wrdpj_pkg::SUM_W-1:0] mid_acc   = '0;
  logic [wrdpj_pkg::SUM_W-1:0] right_acc = '0;

  wrdpj_pkg::res_t frame_results_q[$];
  int unsigned     mismatches;
  int unsigned     pixels_sent;
  bit              steady;     // no gaps on either side
  bit              hold_req;   // receiver holds off for HOLD_CYCLES

  weighted_region_dark_pixel_judge #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : run_limit
    #20_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned lo,
                                            input int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [wrdpj_pkg::SUM_W-1:0] sum_add(
      input logic [wrdpj_pkg::SUM_W-1:0] s, input int unsigned w);
    int unsigned t;
    t = s + w;
    return (t > wrdpj_pkg::SUM_MAX) ? wrdpj_pkg::SUM_MAX : wrdpj_pkg::SUM_W'(t);
  endfunction

  // Ratios cross-multiplied against Q1.24 thresholds
  function automatic logic [wrdpj_pkg::VERD_W-1:0] frame_verdict(input int unsigned rows,
                                                                 input int unsigned cols);
    longint area, full, unit, up, lo, kb, kw, kt, dk, lt, md, rt;
    area = longint'(rows) * longint'(cols);
    up   = longint'(cfg_upper);
    lo   = longint'(cfg_lower);
    kb   = longint'(thr_black);
    kw   = longint'(thr_white);
    kt   = longint'(thr_turn);
    dk   = longint'(dark_acc);
    lt   = longint'(left_acc);
    md   = longint'(mid_acc);
    rt   = longint'(right_acc);
    full = (area / 2) * up + (area / 2) * lo;
    unit = longint'(1) << wrdpj_pkg::FRAC_W;
    if (dk * unit > kb * full) return wrdpj_pkg::VERDICT_BLACK;
    if ((full - dk) * unit > kw * full) return wrdpj_pkg::VERDICT_WHITE;
    if (lt >= rt) begin
      if (((lt >= md) ? lt - md : md - lt) * unit > kt * full) return wrdpj_pkg::VERDICT_LEFT;
    end else if (((rt >= md) ? rt - md : md - rt) * unit > kt * full) begin
      return wrdpj_pkg::VERDICT_RIGHT;
    end
    return wrdpj_pkg::VERDICT_NONE;
  endfunction

  // Advance the frame by one accepted pixel
  task automatic judge_pixel(input wrdpj_pkg::pix_t p);
    int unsigned     rows, cols, wt;
    wrdpj_pkg::res_t res;
    rows = clamp_dim(32'(cfg_rows), 2, MAX_ROWS);
    cols = clamp_dim(32'(cfg_cols), 4, MAX_COLS);
    if (p.blue == '0 && p.green == '0 && p.red == '0) begin
      wt = (row_at < rows / 2) ? 32'(cfg_upper) : 32'(cfg_lower);
      dark_acc = sum_add(dark_acc, wt);
      if (col_at < cols * 2 / 4) left_acc = sum_add(left_acc, wt);
      if (col_at >= cols / 4 && col_at < cols * 3 / 4) mid_acc = sum_add(mid_acc, wt);
      if (col_at >= cols * 2 / 4) right_acc = sum_add(right_acc, wt);
    end
    if (col_at + 1 < cols) begin
      col_at++;
    end else begin
      col_at = 0;
      if (row_at + 1 < rows) begin
        row_at++;
      end else begin
        res.verdict       = frame_verdict(rows, cols);
        res.weighted_dark = dark_acc;
        res.left_sum      = left_acc;
        res.middle_sum    = mid_acc;
        res.right_sum     = right_acc;
        frame_results_q.push_back(res);
        row_at    = 0;
        dark_acc  = '0;
        left_acc  = '0;
        mid_acc   = '0;
        right_acc = '0;
      end
    end
  endtask

  // ------------------------------------------------------------------ drivers

  function automatic int unsigned pause_len();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Send one pixel word; called and returns at a rising edge
  task automatic push_pixel(input wrdpj_pkg::pix_t p);
    int unsigned gap;
    bit          taken;
    cfg_valid_i <= 1'b0;
    gap = pause_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= p;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    pixels_sent++;
    judge_pixel(p);
  endtask

  // Register write; valid is dropped by whatever follows in the same step
  task automatic reg_write(input logic [wrdpj_pkg::CFG_A_W-1:0] idx,
                           input logic [wrdpj_pkg::THR_W-1:0] data);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    case (idx)
      wrdpj_pkg::CFG_FRAME_ROWS:   cfg_rows  = data[wrdpj_pkg::DIM_W-1:0];
      wrdpj_pkg::CFG_FRAME_COLS:   cfg_cols  = data[wrdpj_pkg::DIM_W-1:0];
      wrdpj_pkg::CFG_UPPER_WEIGHT: cfg_upper = data[wrdpj_pkg::WGT_W-1:0];
      wrdpj_pkg::CFG_LOWER_WEIGHT: cfg_lower = data[wrdpj_pkg::WGT_W-1:0];
      wrdpj_pkg::CFG_BLACK_THR:    thr_black = data;
      wrdpj_pkg::CFG_WHITE_THR:    thr_white = data;
      wrdpj_pkg::CFG_TURN_THR:     thr_turn  = data;
      default: ;
    endcase
  endtask

  // Idle both request channels, wait for every result, let the sequencer finish
  task automatic wait_drained();
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    wait (frame_results_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_size(input int unsigned rows, input int unsigned cols);
    reg_write(wrdpj_pkg::CFG_FRAME_ROWS, {15'($urandom), wrdpj_pkg::DIM_W'(rows)});
    reg_write(wrdpj_pkg::CFG_FRAME_COLS, {15'($urandom), wrdpj_pkg::DIM_W'(cols)});
  endtask

  task automatic set_weights(input int unsigned up, input int unsigned lo);
    reg_write(wrdpj_pkg::CFG_UPPER_WEIGHT, {21'($urandom), wrdpj_pkg::WGT_W'(up)});
    reg_write(wrdpj_pkg::CFG_LOWER_WEIGHT, {21'($urandom), wrdpj_pkg::WGT_W'(lo)});
  endtask

  task automatic set_thresholds(input logic [wrdpj_pkg::THR_W-1:0] kb,
                                input logic [wrdpj_pkg::THR_W-1:0] kw,
                                input logic [wrdpj_pkg::THR_W-1:0] kt);
    reg_write(wrdpj_pkg::CFG_BLACK_THR, kb);
    reg_write(wrdpj_pkg::CFG_WHITE_THR, kw);
    reg_write(wrdpj_pkg::CFG_TURN_THR, kt);
  endtask

  // Channels biased towards the extremes
  function automatic logic [wrdpj_pkg::CHAN_W-1:0] chan_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return '0;
    if (r < 5) return '1;
    return wrdpj_pkg::CHAN_W'($urandom_range(1, 254));
  endfunction

  function automatic wrdpj_pkg::pix_t make_pixel(input shape_e shape,
                                                 input int unsigned dark_pct);
    wrdpj_pkg::pix_t p;
    int unsigned     cols, pct;
    cols = clamp_dim(32'(cfg_cols), 4, MAX_COLS);
    case (shape)
      SHAPE_LEFT:   pct = (col_at < cols / 2) ? 90 : 10;
      SHAPE_RIGHT:  pct = (col_at >= cols / 2) ? 90 : 10;
      SHAPE_MIDDLE: pct = (col_at >= cols / 4 && col_at < cols * 3 / 4) ? 90 : 10;
      default:      pct = dark_pct;
    endcase
    if ($urandom_range(0, 99) < pct) return '0;
    p.blue  = chan_value();
    p.green = chan_value();
    p.red   = chan_value();
    return p;
  endfunction

  // Pixels until the predicted position wraps back to the frame start
  task automatic send_frame(input shape_e shape, input int unsigned dark_pct);
    do begin
      push_pixel(make_pixel(shape, dark_pct));
    end while (row_at != 0 || col_at != 0);
  endtask

  // ------------------------------------------------------------- result side

  initial begin : rx_stall
    int unsigned r, free_run, hold;
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (steady) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        free_run = (r < 50) ? $urandom_range(1, 4) : ((r < 90) ? $urandom_range(5, 20) : 1);
        r = $urandom_range(0, 99);
        if (r < 30)      hold = 0;
        else if (r < 80) hold = $urandom_range(1, 3);
        else if (r < 96) hold = $urandom_range(4, 12);
        else             hold = $urandom_range(20, 60);
        out_stall_i <= 1'b0;
        repeat (free_run) @(posedge clk_i);
        if (hold > 0) begin
          out_stall_i <= 1'b1;
          repeat (hold) @(posedge clk_i);
        end
      end
    end
  end

  function automatic void check_field(input string name,
                                      input logic [wrdpj_pkg::SUM_W-1:0] want,
                                      input logic [wrdpj_pkg::SUM_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Inputs only move at rising edges, so the handshake is settled by the falling one
  always @(negedge clk_i) begin : result_check
    wrdpj_pkg::res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frame_results_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word, expected none, actual %p", $time, out_word_o);
      end else begin
        want = frame_results_q.pop_front();
        check_field("verdict", wrdpj_pkg::SUM_W'(want.verdict),
                    wrdpj_pkg::SUM_W'(out_word_o.verdict));
        check_field("weighted_dark", want.weighted_dark, out_word_o.weighted_dark);
        check_field("left_sum", want.left_sum, out_word_o.left_sum);
        check_field("middle_sum", want.middle_sum, out_word_o.middle_sum);
        check_field("right_sum", want.right_sum, out_word_o.right_sum);
      end
    end
  end

  // -------------------------------------------------------------------- tests

  // Smallest frame: all dark, all light with channel extremes, dark on the left
  task automatic test_directed_frames();
    wrdpj_pkg::pix_t light[8] = '{24'hFFFFFF, 24'h010000, 24'h000100, 24'h000001,
                                  24'h800000, 24'h008000, 24'h000080, 24'hFE7F01};
    set_size(2, 4);
    repeat (8) push_pixel('0);
    foreach (light[i]) push_pixel(light[i]);
    repeat (2) begin
      push_pixel('0);
      push_pixel('0);
      push_pixel(24'hFF00FF);
      push_pixel(24'h00FF00);
    end
    wait_drained();
  endtask

  // Sizes below the minimum clamp up
  task automatic test_size_clamps();
    set_size(0, 0);
    send_frame(SHAPE_RIGHT, 0);
    wait_drained();
    set_size(1, 3);
    send_frame(SHAPE_FLAT, 50);
    wait_drained();
  endtask

  task automatic test_zero_weights();
    set_size(2, 4);
    set_weights(0, 0);
    send_frame(SHAPE_FLAT, 100);
    send_frame(SHAPE_LEFT, 0);
    wait_drained();
    set_weights(0, 9);
    send_frame(SHAPE_LEFT, 0);
    wait_drained();
    set_weights(15, 0);
    send_frame(SHAPE_FLAT, 60);
    wait_drained();
    set_weights(15, 15);
  endtask

  // Thresholds at zero, exactly one and the field maximum
  task automatic test_threshold_edges();
    set_size(2, 8);
    set_thresholds('0, 25'd15938355, 25'd8389);
    send_frame(SHAPE_LEFT, 0);
    wait_drained();
    set_thresholds('1, '0, 25'd8389);
    send_frame(SHAPE_RIGHT, 0);
    wait_drained();
    set_thresholds('1, '1, '0);
    send_frame(SHAPE_RIGHT, 0);
    send_frame(SHAPE_MIDDLE, 0);
    wait_drained();
    set_thresholds(25'h1000000, 25'h1000000, '1);
    send_frame(SHAPE_LEFT, 0);
    send_frame(SHAPE_FLAT, 0);
    send_frame(SHAPE_FLAT, 100);
    wait_drained();
    set_thresholds(25'h1000000, 25'h1000000, 25'd8389);
    send_frame(SHAPE_FLAT, 100);
    wait_drained();
    set_thresholds(25'd15938355, 25'd15938355, 25'd8389);
  endtask

  task automatic test_spare_index();
    reg_write(CFG_SPARE, '1);
    send_frame(SHAPE_FLAT, 50);
    wait_drained();
  endtask

  // Shrink the frame while a row and then the frame is under way
  task automatic test_mid_frame_resize();
    set_size(4, 8);
    repeat (6) push_pixel(make_pixel(SHAPE_FLAT, 50));
    wait_drained();
    reg_write(wrdpj_pkg::CFG_FRAME_COLS, {15'($urandom), wrdpj_pkg::DIM_W'(4)});
    repeat (9) push_pixel(make_pixel(SHAPE_FLAT, 50));
    wait_drained();
    reg_write(wrdpj_pkg::CFG_FRAME_ROWS, {15'($urandom), wrdpj_pkg::DIM_W'(2)});
    send_frame(SHAPE_FLAT, 50);
    wait_drained();
  endtask

  // Receiver holds off long enough for the block to back up into its input
  task automatic test_back_pressure();
    set_size(2, 4);
    hold_req = 1'b1;
    repeat (6) send_frame(SHAPE_FLAT, $urandom_range(0, 100));
    wait_drained();
  endtask

  function automatic logic [wrdpj_pkg::DIM_W-1:0] pick_dim(input int unsigned lo,
                                                           input int unsigned hi,
                                                           input int unsigned wide);
    if ($urandom_range(0, 99) < 85) return wrdpj_pkg::DIM_W'($urandom_range(lo, hi));
    return wrdpj_pkg::DIM_W'($urandom_range(0, wide));
  endfunction

  function automatic logic [wrdpj_pkg::THR_W-1:0] pick_threshold(
      input logic [wrdpj_pkg::THR_W-1:0] typical, input int unsigned span);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 25'h1000000;
      2:       return '1;
      3, 4:    return typical;
      default: return wrdpj_pkg::THR_W'($urandom_range(0, span));
    endcase
  endfunction

  task automatic test_random_frames();
    int unsigned start;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      wait_drained();
      steady = ($urandom_range(0, 4) == 0);
      set_size(pick_dim(2, 4, 8), pick_dim(4, 8, 16));
      if ($urandom_range(0, 1))
        set_weights(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 15),
                    ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 15));
      if ($urandom_range(0, 1))
        set_thresholds(pick_threshold(25'd15938355, 25'h1000000),
                       pick_threshold(25'd15938355, 25'h1000000),
                       pick_threshold(25'd8389, 25'h400000));
      repeat ($urandom_range(1, 4))
        send_frame(shape_e'($urandom_range(0, 3)), $urandom_range(0, 100));
    end
    steady = 1'b0;
  endtask

  initial begin : main
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_word_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_frames();
    test_size_clamps();
    test_zero_weights();
    test_threshold_edges();
    test_spare_index();
    test_mid_frame_resize();
    test_back_pressure();
    test_random_frames();

    wait_drained();
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/wrdpj_pkg.sv
rtl/wrdpj_mul.sv
rtl/wrdpj_acc.sv
rtl/wrdpj_judge.sv
rtl/weighted_region_dark_pixel_judge.sv
tb/sv/tb_top.sv
